>>> src/wpb_pkg.sv
// Shared constants, state encoding and control/status bundles for the weight partition balancer.
`default_nettype none
package wpb_pkg;
    localparam int MAX_WEIGHTS = 64;
    localparam int MAX_PARTS   = 64;
    localparam int WEIGHT_W    = 16;
    localparam int COUNT_W     = $clog2(MAX_WEIGHTS + 1);
    localparam int ADDR_W      = $clog2(MAX_WEIGHTS);
    localparam int PART_W      = 6;
    localparam int PCNT_W      = 7;
    localparam int LOAD_W      = 22;
    localparam int DVD_W       = LOAD_W + 4;
    localparam int DVS_W       = 10;
    localparam int DCNT_W      = $clog2(DVD_W);

    typedef enum logic [3:0] {
        S_LOAD,
        S_CHECK,
        S_DIV,
        S_PASS_RD,
        S_PASS_EV,
        S_GR_START,
        S_GR_RD,
        S_GR_PREV,
        S_GR_SRD,
        S_GR_SCMP,
        S_GR_WR,
        S_EM_RD,
        S_EM_CAP
    } state_t;

    typedef struct packed {
        logic load;
        logic check;
        logic div_step;
        logic pass_ev;
        logic gr_clr;
        logic gr_rd_prev;
        logic gr_prev;
        logic gr_cmp;
        logic gr_wr;
        logic em_cap;
    } cmd_t;

    typedef struct packed {
        logic direct;
        logic div_done;
        logic pass_more;
        logic left;
        logic scan_last;
        logic gr_last;
        logic out_free;
        logic em_last;
    } status_t;
endpackage
`default_nettype wire

>>> src/weight_partition_balancer.sv
// Top level of the weight partition balancer: sequencer plus datapath.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+-----------------------------------
//  input     | in_valid / in_ready        | weight, last_weight
//  result    | out_valid / out_ready      | load_pos, part, dropped, last
//  config    | cfg_wr_en                  | cfg_wr_data (part_count)
//
//  Loading takes one weight per cycle. After the last-marked beat a check
//  step sends the set straight to output when the weight count equals the
//  part count; otherwise the average divider runs, then the sequential pass,
//  a step that clears the greedy loads, and a greedy scan over the load RAM per leftover weight.
//  Each result waits on out_ready while the output register is full; in_ready
//  returns as soon as the final result is in the output register.
//  Reset clears the set and sets the part count to 1.
`default_nettype none
module weight_partition_balancer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [wpb_pkg::PCNT_W-1:0]    cfg_wr_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [wpb_pkg::WEIGHT_W-1:0]  weight,
    input  wire logic                          last_weight,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [wpb_pkg::ADDR_W-1:0]         load_pos,
    output logic [wpb_pkg::PART_W-1:0]         part,
    output logic                               dropped,
    output logic                               last
);
    wpb_pkg::cmd_t    cmd;
    wpb_pkg::status_t st;

    wpb_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .last_weight (last_weight),
        .st          (st),
        .cmd         (cmd)
    );

    wpb_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .weight       (weight),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .load_pos     (load_pos),
        .part         (part),
        .dropped      (dropped),
        .last         (last)
    );

    assign in_ready = cmd.load;
endmodule
`default_nettype wire

>>> src/wpb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module wpb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> src/wpb_ctrl.sv
// Phase sequencer for loading, averaging, sequential pass, greedy placement and result output.
`default_nettype none
module wpb_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             last_weight,
    input  wire wpb_pkg::status_t st,
    output wpb_pkg::cmd_t         cmd
);
    wpb_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wpb_pkg::S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wpb_pkg::S_LOAD:
            begin
                if (in_valid && last_weight)
                begin
                    state_next = wpb_pkg::S_CHECK;
                end
            end
            wpb_pkg::S_CHECK:
            begin
                state_next = st.direct ? wpb_pkg::S_EM_RD : wpb_pkg::S_DIV;
            end
            wpb_pkg::S_DIV:
            begin
                if (st.div_done)
                begin
                    state_next = wpb_pkg::S_PASS_RD;
                end
            end
            wpb_pkg::S_PASS_RD:
            begin
                if (st.pass_more)
                begin
                    state_next = wpb_pkg::S_PASS_EV;
                end
                else if (st.left)
                begin
                    state_next = wpb_pkg::S_GR_START;
                end
                else
                begin
                    state_next = wpb_pkg::S_EM_RD;
                end
            end
            wpb_pkg::S_PASS_EV:  state_next = wpb_pkg::S_PASS_RD;
            wpb_pkg::S_GR_START: state_next = wpb_pkg::S_GR_RD;
            wpb_pkg::S_GR_RD:    state_next = wpb_pkg::S_GR_PREV;
            wpb_pkg::S_GR_PREV:  state_next = wpb_pkg::S_GR_SRD;
            wpb_pkg::S_GR_SRD:   state_next = wpb_pkg::S_GR_SCMP;
            wpb_pkg::S_GR_SCMP:
            begin
                state_next = st.scan_last ? wpb_pkg::S_GR_WR : wpb_pkg::S_GR_SRD;
            end
            wpb_pkg::S_GR_WR:
            begin
                state_next = st.gr_last ? wpb_pkg::S_EM_RD : wpb_pkg::S_GR_RD;
            end
            wpb_pkg::S_EM_RD:    state_next = wpb_pkg::S_EM_CAP;
            wpb_pkg::S_EM_CAP:
            begin
                if (st.out_free)
                begin
                    state_next = st.em_last ? wpb_pkg::S_LOAD : wpb_pkg::S_EM_RD;
                end
            end
            default:             state_next = wpb_pkg::S_LOAD;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            wpb_pkg::S_LOAD:     cmd.load = 1'b1;
            wpb_pkg::S_CHECK:    cmd.check = 1'b1;
            wpb_pkg::S_DIV:      cmd.div_step = 1'b1;
            wpb_pkg::S_PASS_RD:  cmd = '0;
            wpb_pkg::S_PASS_EV:  cmd.pass_ev = 1'b1;
            wpb_pkg::S_GR_START: cmd.gr_clr = 1'b1;
            wpb_pkg::S_GR_RD:    cmd.gr_rd_prev = 1'b1;
            wpb_pkg::S_GR_PREV:  cmd.gr_prev = 1'b1;
            wpb_pkg::S_GR_SRD:   cmd = '0;
            wpb_pkg::S_GR_SCMP:  cmd.gr_cmp = 1'b1;
            wpb_pkg::S_GR_WR:    cmd.gr_wr = 1'b1;
            wpb_pkg::S_EM_RD:    cmd = '0;
            wpb_pkg::S_EM_CAP:   cmd.em_cap = st.out_free;
            default:             cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

>>> src/wpb_datapath.sv
// Weight storage, average divider, part counters, greedy loads and output register.
`default_nettype none
module wpb_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire wpb_pkg::cmd_t                 cmd,
    output wpb_pkg::status_t                   st,
    input  wire logic                          cfg_wr_en,
    input  wire logic [wpb_pkg::PCNT_W-1:0]    cfg_wr_data,
    input  wire logic                          in_valid,
    input  wire logic [wpb_pkg::WEIGHT_W-1:0]  weight,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [wpb_pkg::ADDR_W-1:0]         load_pos,
    output logic [wpb_pkg::PART_W-1:0]         part,
    output logic                               dropped,
    output logic                               last
);
    localparam int AW = wpb_pkg::ADDR_W;
    localparam int CW = wpb_pkg::COUNT_W;
    localparam int PW = wpb_pkg::PCNT_W;
    localparam int LW = wpb_pkg::LOAD_W;
    localparam int DW = wpb_pkg::DVD_W;
    localparam int VW = wpb_pkg::DVS_W;

    logic [PW-1:0]  pcnt_reg;
    logic [CW-1:0]  count_reg;
    logic [LW-1:0]  total_reg;
    logic           ovf_reg;
    logic           direct_reg;
    logic [DW-1:0]  dvd_reg;
    logic [VW-1:0]  rem_reg;
    logic [wpb_pkg::DCNT_W-1:0] dcnt_reg;
    logic [CW-1:0]  idx_reg;
    logic [PW-1:0]  p_reg;
    logic [LW-1:0]  load_reg;
    logic           held_reg;
    logic [wpb_pkg::MAX_PARTS-1:0] glv_reg;
    logic [AW-1:0]  prev_reg, best_reg, scan_reg, emit_reg;
    logic [LW-1:0]  bestload_reg;
    logic [wpb_pkg::WEIGHT_W-1:0] w_reg;
    logic           out_valid_reg;
    logic [AW-1:0]  index_reg;
    logic [wpb_pkg::PART_W-1:0] part_reg;
    logic           dropped_reg, last_reg;

    logic [PW-1:0]  parts;
    logic [VW-1:0]  divisor;
    logic [VW:0]    rem_sh;
    logic           q_bit;
    logic [LW-1:0]  avg;
    logic [wpb_pkg::WEIGHT_W-1:0] ws_rdata;
    logic [LW-1:0]  gl_rdata, gl_cur, gl_sum, new_load;
    logic [AW-1:0]  gl_raddr;
    logic [wpb_pkg::PART_W-1:0] ap_rdata, ap_wdata;
    logic           ap_we, accept, heavy;

    assign parts = (pcnt_reg == '0) ? PW'(1)
                 : ((pcnt_reg > PW'(wpb_pkg::MAX_PARTS)) ? PW'(wpb_pkg::MAX_PARTS) : pcnt_reg);
    assign divisor = VW'({parts, 3'b000}) + VW'({parts, 1'b0});
    assign rem_sh  = {rem_reg, dvd_reg[DW-1]};
    assign q_bit   = rem_sh >= {1'b0, divisor};
    assign avg     = dvd_reg[LW-1:0];
    assign accept  = cmd.load && in_valid;
    assign new_load = load_reg + LW'(ws_rdata);
    assign heavy   = (LW + 2)'({ws_rdata, 2'b00}) > (LW + 2)'(avg) * (LW + 2)'(3);
    assign gl_raddr = cmd.gr_rd_prev ? prev_reg : scan_reg;
    assign gl_cur  = glv_reg[scan_reg] ? gl_rdata : '0;
    assign gl_sum  = bestload_reg + LW'(w_reg);
    assign ap_we   = (cmd.pass_ev && !(heavy && held_reg)) || cmd.gr_wr;
    assign ap_wdata = cmd.gr_wr ? best_reg : p_reg[wpb_pkg::PART_W-1:0];

    assign st.direct    = count_reg == CW'(parts);
    assign st.div_done  = dcnt_reg == wpb_pkg::DCNT_W'(DW - 1);
    assign st.pass_more = (p_reg < parts) && (idx_reg < count_reg);
    assign st.left      = idx_reg < count_reg;
    assign st.scan_last = PW'(scan_reg) == parts - PW'(1);
    assign st.gr_last   = idx_reg + CW'(1) == count_reg;
    assign st.out_free  = !out_valid_reg || out_ready;
    assign st.em_last   = CW'(emit_reg) + CW'(1) == count_reg;

    wpb_ram #(.WIDTH(wpb_pkg::WEIGHT_W), .DEPTH(wpb_pkg::MAX_WEIGHTS)) u_weights (
        .clk   (clk),
        .we    (accept && (count_reg < CW'(wpb_pkg::MAX_WEIGHTS))),
        .waddr (count_reg[AW-1:0]),
        .wdata (weight),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ws_rdata)
    );

    wpb_ram #(.WIDTH(wpb_pkg::PART_W), .DEPTH(wpb_pkg::MAX_WEIGHTS)) u_assign (
        .clk   (clk),
        .we    (ap_we),
        .waddr (idx_reg[AW-1:0]),
        .wdata (ap_wdata),
        .raddr (emit_reg),
        .rdata (ap_rdata)
    );

    wpb_ram #(.WIDTH(LW), .DEPTH(wpb_pkg::MAX_PARTS)) u_greedy (
        .clk   (clk),
        .we    (cmd.gr_wr),
        .waddr (best_reg),
        .wdata (gl_sum),
        .raddr (gl_raddr),
        .rdata (gl_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcnt_reg      <= PW'(1);
            count_reg     <= '0;
            total_reg     <= '0;
            ovf_reg       <= 1'b0;
            direct_reg    <= 1'b0;
            dcnt_reg      <= '0;
            idx_reg       <= '0;
            p_reg         <= '0;
            load_reg      <= '0;
            held_reg      <= 1'b0;
            glv_reg       <= '0;
            prev_reg      <= '0;
            scan_reg      <= '0;
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                pcnt_reg <= cfg_wr_data;
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                if (count_reg < CW'(wpb_pkg::MAX_WEIGHTS))
                begin
                    count_reg <= count_reg + CW'(1);
                    total_reg <= total_reg + LW'(weight);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.check)
            begin
                direct_reg <= st.direct;
                dcnt_reg   <= '0;
                idx_reg    <= '0;
                p_reg      <= '0;
                load_reg   <= '0;
                held_reg   <= 1'b0;
                emit_reg   <= '0;
            end
            if (cmd.div_step)
            begin
                dcnt_reg <= dcnt_reg + wpb_pkg::DCNT_W'(1);
            end
            if (cmd.pass_ev)
            begin
                if (heavy && held_reg)
                begin
                    p_reg    <= p_reg + PW'(1);
                    load_reg <= '0;
                    held_reg <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg + CW'(1);
                    if (new_load > avg)
                    begin
                        p_reg    <= p_reg + PW'(1);
                        load_reg <= '0;
                        held_reg <= 1'b0;
                    end
                    else
                    begin
                        load_reg <= new_load;
                        held_reg <= 1'b1;
                    end
                end
            end
            if (cmd.gr_clr)
            begin
                glv_reg  <= '0;
                prev_reg <= '0;
            end
            if (cmd.gr_prev)
            begin
                scan_reg <= '0;
            end
            if (cmd.gr_cmp)
            begin
                scan_reg <= scan_reg + AW'(1);
            end
            if (cmd.gr_wr)
            begin
                glv_reg[best_reg] <= 1'b1;
                prev_reg          <= best_reg;
                idx_reg           <= idx_reg + CW'(1);
            end
            if (cmd.em_cap)
            begin
                out_valid_reg <= 1'b1;
                emit_reg      <= emit_reg + AW'(1);
                if (st.em_last)
                begin
                    count_reg <= '0;
                    total_reg <= '0;
                    ovf_reg   <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            dvd_reg <= DW'({total_reg, 3'b000}) + DW'(total_reg);
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[DW-2:0], q_bit};
            rem_reg <= q_bit ? VW'(rem_sh - {1'b0, divisor}) : VW'(rem_sh);
        end
        if (cmd.gr_prev)
        begin
            best_reg     <= prev_reg;
            bestload_reg <= glv_reg[prev_reg] ? gl_rdata : '0;
            w_reg        <= ws_rdata;
        end
        if (cmd.gr_cmp && (gl_cur < bestload_reg))
        begin
            best_reg     <= scan_reg;
            bestload_reg <= gl_cur;
        end
        if (cmd.em_cap)
        begin
            index_reg   <= emit_reg;
            part_reg    <= direct_reg ? emit_reg : ap_rdata;
            dropped_reg <= ovf_reg;
            last_reg    <= st.em_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign load_pos  = index_reg;
    assign part      = part_reg;
    assign dropped   = dropped_reg;
    assign last      = last_reg;
endmodule
`default_nettype wire

>>> src/wpb_checker.sv
// Port-level checks for the weight partition balancer and their bind.
`default_nettype none
module wpb_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic last_weight,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic last
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat withdrawn before taken");

    a_keep_loading: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !last_weight |=> in_ready)
        else $error("input stalled mid-set");

    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_weight |=> !in_ready)
        else $error("input taken right after final weight");

    a_no_load_mid_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |-> !in_ready)
        else $error("input open before set results finished");
endmodule

bind weight_partition_balancer wpb_checker u_wpb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .last_weight (last_weight),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .last        (last)
);
`default_nettype wire
